// File: rtl/pwsr_pkg.sv
// Types and constants shared by the pulse-width serial RPM receiver.
package pwsr_pkg;

  localparam int TIME_W     = 32;
  localparam int WORD_W     = 15;
  localparam int SPEED_W    = 21;
  localparam int EVENT_W    = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int STATE_W    = 3;
  localparam int BITS_W     = 4;
  localparam int SAMPLE_W   = 8;

  localparam int DATA_BITS = 15;

  typedef logic [TIME_W-1:0]     time_t;
  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [SPEED_W-1:0]    speed_t;
  typedef logic [EVENT_W-1:0]    event_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [STATE_W-1:0]    rx_state_t;
  typedef logic [BITS_W-1:0]     bits_t;
  typedef logic [SAMPLE_W-1:0]   sample_t;

  localparam event_t EV_NONE   = 2'd0;
  localparam event_t EV_OK     = 2'd1;
  localparam event_t EV_PARITY = 2'd2;
  localparam event_t EV_ERROR  = 2'd3;

  localparam rx_state_t ST_IDLE        = 3'd0;
  localparam rx_state_t ST_START_LOW   = 3'd1;
  localparam rx_state_t ST_WAIT_DATA   = 3'd2;
  localparam rx_state_t ST_DATA_LOW    = 3'd3;
  localparam rx_state_t ST_WAIT_PARITY = 3'd4;
  localparam rx_state_t ST_PARITY_LOW  = 3'd5;

  localparam cfg_idx_t REG_DEBOUNCE  = 3'd0;
  localparam cfg_idx_t REG_START_MIN = 3'd1;
  localparam cfg_idx_t REG_START_MAX = 3'd2;
  localparam cfg_idx_t REG_ONE_THR   = 3'd3;
  localparam cfg_idx_t REG_TIMEOUT   = 3'd4;

  localparam cfg_data_t DEBOUNCE_RST  = 16'd15;
  localparam cfg_data_t START_MIN_RST = 16'd50;
  localparam cfg_data_t START_MAX_RST = 16'd80;
  localparam cfg_data_t ONE_THR_RST   = 16'd35;
  localparam cfg_data_t TIMEOUT_RST   = 16'd80;

endpackage

// File: rtl/pwsr_in_if.sv
// Input channel carrying one pin edge request: timestamp and new level.
interface pwsr_in_if;
  import pwsr_pkg::*;

  logic  valid;
  logic  ready;
  time_t time_us;
  logic  level;

  modport source (output valid, output time_us, output level, input ready);
  modport sink (input valid, input time_us, input level, output ready);
endinterface

// File: rtl/pwsr_out_if.sv
// Result channel carrying the event code, received word and speed.
interface pwsr_out_if;
  import pwsr_pkg::*;

  logic   valid;
  logic   ready;
  event_t event_res;
  word_t  word;
  speed_t speed;

  modport source (output valid, output event_res, output word, output speed, input ready);
  modport sink (input valid, input event_res, input word, input speed, output ready);
endinterface

// File: rtl/pulse_width_serial_rpm_receiver_top.sv
// Pulse-width serial RPM receiver: edge decoder, moving-sum ring and speed output.
// The block takes one edge request per clock cycle and gives exactly one result
// request for each in the next cycle, from an output register. It stays ready while
// that register is empty or being drained, so one edge per cycle is sustained for
// as long as the result side takes every cycle. The whole frame decoder step is a
// single pass of logic; the moving-sum ring is a WINDOW-entry memory whose next slot
// is read ahead into a register, so the oldest sample is on hand when a word lands.
// The ring is zero after reset through per-entry valid bits, with no clearing pass.
module pulse_width_serial_rpm_receiver_top #(
  parameter int WINDOW = 50
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  pwsr_in_if.sink                                in_if,
  pwsr_out_if.source                             out_if,
  input  logic                                   cfg_we,
  input  logic [pwsr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pwsr_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import pwsr_pkg::*;

  localparam int PTR_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W       = $clog2(255 * WINDOW + 1);
  localparam int SPEED_SCALE = (1000 / (WINDOW * 10)) * 60;
  localparam int SCALE_W     = (SPEED_SCALE > 1) ? $clog2(SPEED_SCALE + 1) : 1;
  localparam int PROD_W      = (SUM_W + SCALE_W > SPEED_W) ? SUM_W + SCALE_W : SPEED_W;

  cfg_data_t debounce_r, start_min_r, start_max_r, one_thr_r, timeout_r;

  rx_state_t        state_r, state_nxt;
  time_t            pulse_start_r, pulse_start_nxt;
  time_t            last_edge_r, last_edge_nxt;
  word_t            shift_r, shift_nxt;
  logic             parity_r, parity_nxt;
  bits_t            bits_r, bits_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [WINDOW-1:0] fill_r;

  sample_t ring_mem [WINDOW];
  sample_t mem_rd_r;
  logic    rd_fill_r;
  logic    rd_byp_r;
  sample_t byp_data_r;
  sample_t old_sample;
  sample_t new_sample;

  logic   out_valid_r;
  event_t event_r, event_nxt;
  word_t  word_r, word_nxt;
  speed_t speed_r, speed_nxt;

  logic              in_ready;
  logic              accept;
  logic              push;
  logic              err;
  logic              high;
  time_t             gap;
  time_t             dt;
  bits_t             pos;
  logic [PROD_W-1:0] prod;

  assign in_ready     = !out_valid_r || out_if.ready;
  assign in_if.ready  = in_ready;
  assign accept       = in_if.valid && in_ready;
  assign out_if.valid = out_valid_r;
  assign out_if.event_res = event_r;
  assign out_if.word  = word_r;
  assign out_if.speed = speed_r;

  assign old_sample = rd_byp_r ? byp_data_r : (rd_fill_r ? mem_rd_r : '0);
  assign new_sample = shift_r[SAMPLE_W-1:0];

  always_comb begin
    high            = in_if.level;
    gap             = in_if.time_us - last_edge_r;
    dt              = in_if.time_us - pulse_start_r;
    pos             = BITS_W'(DATA_BITS - 1) - bits_r;
    state_nxt       = state_r;
    pulse_start_nxt = pulse_start_r;
    last_edge_nxt   = last_edge_r;
    shift_nxt       = shift_r;
    parity_nxt      = parity_r;
    bits_nxt        = bits_r;
    event_nxt       = EV_NONE;
    word_nxt        = '0;
    err             = 1'b0;
    push            = 1'b0;
    if (gap >= {{(TIME_W - CFG_DATA_W){1'b0}}, debounce_r}) begin
      last_edge_nxt = in_if.time_us;
      unique case (state_r)
        ST_IDLE: begin
          if (!high) begin
            pulse_start_nxt = in_if.time_us;
            state_nxt       = ST_START_LOW;
          end
        end
        ST_START_LOW: begin
          if (!high) begin
            err = 1'b1;
          end else if (dt > TIME_W'(start_min_r) && dt < TIME_W'(start_max_r)) begin
            bits_nxt   = BITS_W'(DATA_BITS - 1);
            shift_nxt  = '0;
            parity_nxt = 1'b0;
            state_nxt  = ST_WAIT_DATA;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
        ST_WAIT_DATA, ST_WAIT_PARITY: begin
          if (high) begin
            err = 1'b1;
          end else begin
            pulse_start_nxt = in_if.time_us;
            state_nxt = (state_r == ST_WAIT_DATA) ? ST_DATA_LOW : ST_PARITY_LOW;
          end
        end
        ST_DATA_LOW: begin
          if (!high || dt > TIME_W'(timeout_r)) begin
            err = 1'b1;
          end else begin
            if (dt > TIME_W'(one_thr_r)) begin
              shift_nxt  = shift_r | (WORD_W'(1) << pos);
              parity_nxt = !parity_r;
            end
            if (bits_r == '0) begin
              state_nxt = ST_WAIT_PARITY;
            end else begin
              bits_nxt  = bits_r - BITS_W'(1);
              state_nxt = ST_WAIT_DATA;
            end
          end
        end
        ST_PARITY_LOW: begin
          if (!high || dt > TIME_W'(timeout_r)) begin
            err = 1'b1;
          end else begin
            word_nxt = shift_r;
            if ((dt > TIME_W'(one_thr_r)) != parity_r) begin
              event_nxt = EV_PARITY;
            end else begin
              event_nxt = EV_OK;
              push      = 1'b1;
            end
            state_nxt = ST_IDLE;
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase
      if (err) begin
        event_nxt = EV_ERROR;
        word_nxt  = '0;
        state_nxt = ST_IDLE;
      end
    end

    ptr_nxt = ptr_r;
    sum_nxt = sum_r;
    if (push) begin
      ptr_nxt = (ptr_r == PTR_W'(WINDOW - 1)) ? '0 : ptr_r + PTR_W'(1);
      sum_nxt = sum_r - SUM_W'(old_sample) + SUM_W'(new_sample);
    end
    prod      = PROD_W'(sum_nxt) * PROD_W'(SPEED_SCALE);
    speed_nxt = prod[SPEED_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= DEBOUNCE_RST;
      start_min_r <= START_MIN_RST;
      start_max_r <= START_MAX_RST;
      one_thr_r   <= ONE_THR_RST;
      timeout_r   <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:  debounce_r  <= cfg_wdata;
        REG_START_MIN: start_min_r <= cfg_wdata;
        REG_START_MAX: start_max_r <= cfg_wdata;
        REG_ONE_THR:   one_thr_r   <= cfg_wdata;
        REG_TIMEOUT:   timeout_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pulse_start_r <= '0;
      last_edge_r   <= '0;
      shift_r       <= '0;
      parity_r      <= 1'b0;
      bits_r        <= '0;
      ptr_r         <= '0;
      sum_r         <= '0;
      fill_r        <= '0;
      rd_fill_r     <= 1'b0;
      rd_byp_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        state_r       <= state_nxt;
        pulse_start_r <= pulse_start_nxt;
        last_edge_r   <= last_edge_nxt;
        shift_r       <= shift_nxt;
        parity_r      <= parity_nxt;
        bits_r        <= bits_nxt;
        ptr_r         <= ptr_nxt;
        sum_r         <= sum_nxt;
        out_valid_r   <= 1'b1;
        if (push) begin
          fill_r[ptr_r] <= 1'b1;
        end
        rd_fill_r <= fill_r[ptr_nxt];
        rd_byp_r  <= push && (ptr_r == ptr_nxt);
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && push) begin
      ring_mem[ptr_r] <= new_sample;
    end
    if (accept) begin
      mem_rd_r <= ring_mem[ptr_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byp_data_r <= new_sample;
      event_r    <= event_nxt;
      word_r     <= word_nxt;
      speed_r    <= speed_nxt;
    end
  end

endmodule
